// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: clocked on clk, off while rst is high.
`define QTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define QTE_ASSERT_IMPL(label, ante, cons, msg) \
  `QTE_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
  `QTE_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

  localparam int QW       = 32;  // quaternion / angle port width
  localparam int PW       = 34;  // floored Q.30 product
  localparam int RW       = 37;  // matrix term
  localparam int LW       = 33;  // lock product factor, clamped to +-2
  localparam int CW       = 40;  // CORDIC x/y datapath
  localparam int AW       = 33;  // CORDIC angle accumulator, Q.29
  localparam int TW       = 31;  // lock threshold
  localparam int RAD_W    = 61;  // asin radicand, up to 2^60
  localparam int SW       = 63;  // square root working width
  localparam int RT_W     = 31;  // square root result, up to 2^30
  localparam int SQ_STEPS = 31;  // one result bit per stage
  localparam int ITER_DEF = 24;
  localparam int ITER_MAX = 30;

  localparam logic signed [AW-1:0] HALF_PI    = 33'sd843314857;
  localparam logic [TW-1:0]        LOCK_RESET = 31'd1073740750;

  localparam logic signed [AW-1:0] ATAN_TAB [ITER_MAX] = '{
    33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579, 33'sd33510843,
    33'sd16771758,  33'sd8387925,   33'sd4194219,   33'sd2097141,  33'sd1048575,
    33'sd524288,    33'sd262144,    33'sd131072,    33'sd65536,    33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,     33'sd1024,
    33'sd512,       33'sd256,       33'sd128,       33'sd64,       33'sd32,
    33'sd16,        33'sd8,         33'sd4,         33'sd2,        33'sd1
  };

  // Operands handed from the matrix front end to the angle back end.
  typedef struct packed {
    logic                  lock;
    logic                  r31_pos;
    logic signed [CW-1:0]  roll_y;
    logic signed [CW-1:0]  roll_x;
    logic signed [CW-1:0]  yaw_y;
    logic signed [CW-1:0]  yaw_x;
    logic signed [CW-1:0]  asin_y;
  } side_t;

  typedef struct packed {
    logic lock;
    logic r31_pos;
  } flag_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [AW-1:0] a);
    logic signed [QW-1:0] r;
    if (a[AW-1] != a[AW-2]) begin
      r = a[AW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      r = a[QW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qte_matrix.sv -----
`default_nettype none
module qte_matrix
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic [TW-1:0]        lock_threshold,
  output logic                 out_valid,
  output side_t                side,
  output logic [RAD_W-1:0]     radicand
);

  function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[2*QW-1:30];
  endfunction

  function automatic logic signed [LW-1:0] clamp2(input logic signed [RW-1:0] v);
    logic signed [LW-1:0] r;
    if (v > RW'(64'sd2147483648)) begin
      r = LW'(64'sd2147483648);
    end else if (v < -RW'(64'sd2147483648)) begin
      r = -LW'(64'sd2147483648);
    end else begin
      r = v[LW-1:0];
    end
    return r;
  endfunction

  // stage A: the ten products
  logic                 a_valid;
  logic signed [PW-1:0] a_ww, a_xx, a_yy, a_zz, a_xy, a_wz, a_xz, a_wy, a_yz, a_wx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_ww <= mulq(quat_w, quat_w);
      a_xx <= mulq(quat_x, quat_x);
      a_yy <= mulq(quat_y, quat_y);
      a_zz <= mulq(quat_z, quat_z);
      a_xy <= mulq(quat_x, quat_y);
      a_wz <= mulq(quat_w, quat_z);
      a_xz <= mulq(quat_x, quat_z);
      a_wy <= mulq(quat_w, quat_y);
      a_yz <= mulq(quat_y, quat_z);
      a_wx <= mulq(quat_w, quat_x);
    end
  end

  // stage B: matrix terms and lock decision
  logic signed [RW-1:0] r11, r21, r31, r32, r33, r12, r13;
  logic [RW-1:0]        mag;
  logic                 lock;

  always_comb begin
    r11 = RW'(a_ww) + RW'(a_xx) - RW'(a_yy) - RW'(a_zz);
    r33 = RW'(a_ww) - RW'(a_xx) - RW'(a_yy) + RW'(a_zz);
    r21 = (RW'(a_xy) + RW'(a_wz)) <<< 1;
    r31 = (RW'(a_xz) - RW'(a_wy)) <<< 1;
    r32 = (RW'(a_yz) + RW'(a_wx)) <<< 1;
    r12 = (RW'(a_xy) - RW'(a_wz)) <<< 1;
    r13 = (RW'(a_xz) + RW'(a_wy)) <<< 1;
    mag  = (r31 < 0) ? $unsigned(-r31) : $unsigned(r31);
    lock = mag > RW'(lock_threshold);
  end

  logic                 b_valid, b_lock;
  logic signed [RW-1:0] b_r11, b_r21, b_r31, b_r32, b_r33, b_r12, b_r13;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_lock <= lock;
      b_r11  <= r11;
      b_r21  <= r21;
      b_r31  <= r31;
      b_r32  <= r32;
      b_r33  <= r33;
      b_r12  <= r12;
      b_r13  <= r13;
    end
  end

  // stage C: asin operand squared, lock product
  logic signed [RW-1:0]   neg31;
  logic signed [QW-1:0]   v;
  logic signed [2*QW-1:0] vsq;
  logic signed [2*LW-1:0] lprod;

  always_comb begin
    neg31 = -b_r31;
    if (neg31 > RW'(1073741824)) begin
      v = QW'(1073741824);
    end else if (neg31 < -RW'(1073741824)) begin
      v = -QW'(1073741824);
    end else begin
      v = neg31[QW-1:0];
    end
    vsq   = v * v;
    lprod = clamp2(b_r31) * clamp2(b_r13);
  end

  logic                   c_valid, c_lock, c_r31_pos;
  logic signed [QW-1:0]   c_v;
  logic [RAD_W-1:0]       c_vv;
  logic signed [2*LW-1:0] c_lp;
  logic signed [RW-1:0]   c_r11, c_r21, c_r32, c_r33, c_r12;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_lock    <= b_lock;
      c_r31_pos <= b_r31 > 0;
      c_v       <= v;
      c_vv      <= vsq[RAD_W-1:0];
      c_lp      <= lprod;
      c_r11     <= b_r11;
      c_r21     <= b_r21;
      c_r32     <= b_r32;
      c_r33     <= b_r33;
      c_r12     <= b_r12;
    end
  end

  // stage D: radicand and CORDIC operand selection
  localparam logic [RAD_W-1:0] ONE_SQ = {1'b1, {(RAD_W-1){1'b0}}};
  localparam int LPF = 2*LW - 30;

  logic signed [LPF-1:0] prod;
  side_t                 side_d;

  always_comb begin
    prod           = c_lp[2*LW-1:30];
    side_d.lock    = c_lock;
    side_d.r31_pos = c_r31_pos;
    side_d.roll_y  = CW'(c_r32);
    side_d.roll_x  = CW'(c_r33);
    side_d.asin_y  = CW'(c_v);
    if (c_lock) begin
      side_d.yaw_y = -CW'(c_r12);
      side_d.yaw_x = -CW'(prod);
    end else begin
      side_d.yaw_y = CW'(c_r21);
      side_d.yaw_x = CW'(c_r11);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
    if (en) begin
      side     <= side_d;
      radicand <= ONE_SQ - c_vv;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qte_isqrt.sv -----
`default_nettype none
module qte_isqrt
  import qte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RAD_W-1:0] radicand,
  output logic             out_valid,
  output logic [RT_W-1:0]  root
);

  // bit-by-bit restoring square root, one result bit per stage
  logic [SW-1:0] rem [SQ_STEPS];
  logic [SW-1:0] res [SQ_STEPS];
  logic          vld [SQ_STEPS];

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam int            K   = SQ_STEPS - 1 - s;
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

    logic [SW-1:0] src_rem, src_res, sum;
    logic          src_v, ge;

    if (s == 0) begin : g_first
      assign src_rem = SW'(radicand);
      assign src_res = '0;
      assign src_v   = in_valid;
    end else begin : g_next
      assign src_rem = rem[s-1];
      assign src_res = res[s-1];
      assign src_v   = vld[s-1];
    end

    assign sum = src_res + BIT;
    assign ge  = src_rem >= sum;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= src_v;
      end
      if (en) begin
        rem[s] <= ge ? src_rem - sum : src_rem;
        res[s] <= ge ? (src_res >> 1) + BIT : src_res >> 1;
      end
    end
  end

  assign out_valid = vld[SQ_STEPS-1];
  assign root      = res[SQ_STEPS-1][RT_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/qte_cordic.sv -----
`default_nettype none
module qte_cordic
  import qte_pkg::*;
#(
  parameter int ITER = ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic                 out_valid,
  output logic signed [AW-1:0] angle
);

  logic signed [CW-1:0] xs  [ITER+1];
  logic signed [CW-1:0] ys  [ITER+1];
  logic signed [AW-1:0] ang [ITER+1];
  logic                 zr  [ITER+1];
  logic                 vld [ITER+1];

  // quadrant fold into the right half plane
  logic signed [CW-1:0] px, py;
  logic signed [AW-1:0] pa;

  always_comb begin
    px = x_in;
    py = y_in;
    pa = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        px = y_in;
        py = -x_in;
        pa = HALF_PI;
      end else begin
        px = -y_in;
        py = x_in;
        pa = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      xs[0]  <= px;
      ys[0]  <= py;
      ang[0] <= pa;
      zr[0]  <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        zr[i+1] <= zr[i];
        if (ys[i] >= 0) begin
          xs[i+1]  <= xs[i] + dx;
          ys[i+1]  <= ys[i] - dy;
          ang[i+1] <= ang[i] + ATAN_TAB[i];
        end else begin
          xs[i+1]  <= xs[i] - dx;
          ys[i+1]  <= ys[i] + dy;
          ang[i+1] <= ang[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = vld[ITER];
  assign angle     = zr[ITER] ? '0 : ang[ITER];

endmodule
`default_nettype wire

// ----- rtl/core/quaternion_to_euler_angles_top.sv -----
// Quaternion (w,x,y,z, signed Q2.30) to Z-Y-X Euler angles (signed Q3.29 radians)
// plus a gimbal-lock flag. Fully pipelined: one word accepted per clock while
// in_stall is low, through 4 matrix stages, 31 square-root stages,
// CORDIC_ITERATIONS + 1 CORDIC stages and 1 output register. The square root
// for asin is the longest part of the path. in_stall rises only after out_stall
// has held a finished word and the one-word skid buffer behind it has filled.
// lock_threshold resets to 0.999999; the user writes it through cfg_we/cfg_wdata
// only while the pipeline is empty, which the block itself does not enforce.
`default_nettype none
module quaternion_to_euler_angles_top
  import qte_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = ITER_DEF  // 8..30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [QW-1:0] angle_about_x,
  output logic signed [QW-1:0] angle_about_y,
  output logic signed [QW-1:0] angle_about_z,
  output logic                 gimbal_lock
);

  // Lock threshold register (unsigned Q1.30 magnitude of r31).
  logic [TW-1:0] lock_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= LOCK_RESET;
    end else if (cfg_we) begin
      lock_threshold <= cfg_wdata;
    end
  end

  // Whole pipeline moves together; it holds only while the skid buffer holds a word.
  logic skid_valid;
  logic en;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Front end: products, matrix terms, lock test, asin radicand.
  logic          m_valid;
  side_t         m_side;
  logic [RAD_W-1:0] m_rad;

  qte_matrix u_matrix (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .quat_w         (quat_w),
    .quat_x         (quat_x),
    .quat_y         (quat_y),
    .quat_z         (quat_z),
    .lock_threshold (lock_threshold),
    .out_valid      (m_valid),
    .side           (m_side),
    .radicand       (m_rad)
  );

  // sqrt(1 - v*v) for the asin leg.
  logic            s_valid;
  logic [RT_W-1:0] s_root;

  qte_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_valid),
    .radicand  (m_rad),
    .out_valid (s_valid),
    .root      (s_root)
  );

  // Other operands ride alongside the square root.
  side_t side_dly [SQ_STEPS];
  side_t sd;

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= m_side;
      for (int j = 1; j < SQ_STEPS; j++) begin
        side_dly[j] <= side_dly[j-1];
      end
    end
  end

  assign sd = side_dly[SQ_STEPS-1];

  // Three CORDICs in lockstep: roll, pitch (asin), yaw.
  logic                 c_valid;
  logic signed [AW-1:0] roll_ang, pitch_ang, yaw_ang;

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (sd.roll_y),
    .x_in      (sd.roll_x),
    .out_valid (c_valid),
    .angle     (roll_ang)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (sd.asin_y),
    .x_in      (CW'(s_root)),
    .out_valid (),
    .angle     (pitch_ang)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .y_in      (sd.yaw_y),
    .x_in      (sd.yaw_x),
    .out_valid (),
    .angle     (yaw_ang)
  );

  // Lock flags follow the CORDIC latency.
  flag_t flag_dly [CORDIC_ITERATIONS+1];
  flag_t fl;

  always_ff @(posedge clk) begin
    if (en) begin
      flag_dly[0] <= '{lock: sd.lock, r31_pos: sd.r31_pos};
      for (int j = 1; j <= CORDIC_ITERATIONS; j++) begin
        flag_dly[j] <= flag_dly[j-1];
      end
    end
  end

  assign fl = flag_dly[CORDIC_ITERATIONS];

  // Result word. Under lock: roll 0, pitch -+pi/2 against the sign of r31.
  logic signed [QW-1:0] res_x, res_y, res_z;

  always_comb begin
    res_z = sat32(yaw_ang);
    if (fl.lock) begin
      res_x = '0;
      res_y = sat32(fl.r31_pos ? -HALF_PI : HALF_PI);
    end else begin
      res_x = sat32(roll_ang);
      res_y = sat32(pitch_ang);
    end
  end

  // Output register plus one-word skid.
  logic signed [QW-1:0] sk_x, sk_y, sk_z;
  logic                 sk_lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= c_valid;
    end else if (c_valid) begin
      skid_valid <= 1'b1;
    end

    if (skid_valid) begin
      if (!out_stall) begin
        angle_about_x <= sk_x;
        angle_about_y <= sk_y;
        angle_about_z <= sk_z;
        gimbal_lock   <= sk_lock;
      end
    end else if (!out_valid || !out_stall) begin
      angle_about_x <= res_x;
      angle_about_y <= res_y;
      angle_about_z <= res_z;
      gimbal_lock   <= fl.lock;
    end else begin
      sk_x    <= res_x;
      sk_y    <= res_y;
      sk_z    <= res_z;
      sk_lock <= fl.lock;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qte_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module qte_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [31:0]   angle_about_x,
  input logic signed [31:0]   angle_about_y,
  input logic signed [31:0]   angle_about_z,
  input logic                 gimbal_lock
);

  `QTE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(angle_about_z) && $stable(gimbal_lock), "stalled word changed")
  `QTE_ASSERT_IMPL(a_lock_roll, out_valid && gimbal_lock, angle_about_x == 32'sd0, "roll not zero under lock")
  `QTE_ASSERT_IMPL(a_lock_pitch, out_valid && gimbal_lock, (angle_about_y == 32'sd843314857) || (angle_about_y == -32'sd843314857), "pitch not +-pi/2 under lock")
  `QTE_ASSERT_IMPL(a_stall_cause, in_stall && !$past(in_stall), $past(out_valid && out_stall), "input stalled without output backpressure")

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
`default_nettype wire

// ----- verif/tb_quaternion_to_euler_angles_top.sv -----
`default_nettype none
module tb_quaternion_to_euler_angles_top
  import qte_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS = 24;
  // pipeline depth of the top level, plus margin
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 37 + 10;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [QW-1:0] roll;
    logic signed [QW-1:0] pitch;
    logic signed [QW-1:0] yaw;
    logic                 lock;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [QW-1:0] angle_about_x, angle_about_y, angle_about_z;
  logic gimbal_lock;

  quaternion_to_euler_angles_top #(.CORDIC_ITERATIONS(CORDIC_STEPS)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_about_x(angle_about_x), .angle_about_y(angle_about_y),
    .angle_about_z(angle_about_z), .gimbal_lock(gimbal_lock)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Shadow of the lock threshold register, tracked by the config writes below.
  logic [TW-1:0] lock_thr = LOCK_RESET;

  // Q2.30 product floored back to Q.30
  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC, angle in Q.29
  function automatic longint vec_atan2(longint y, longint x);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = HALF_PI;
      end else begin
        x = -y; y = t; ang = -HALF_PI;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; ang -= ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic logic signed [QW-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[QW-1:0];
  endfunction

  function automatic euler_t euler_of(quat_t q);
    longint w, x, y, z, ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    longint r11, r21, r31, r32, r33, r12, r13, mag, prod, s, c;
    longint one;
    euler_t e;
    one = 64'sd1 << 30;
    w = q.w; x = q.x; y = q.y; z = q.z;
    ww = fmul(w, w); xx = fmul(x, x); yy = fmul(y, y); zz = fmul(z, z);
    xy = fmul(x, y); wz = fmul(w, z); xz = fmul(x, z);
    wy = fmul(w, y); yz = fmul(y, z); wx = fmul(w, x);
    r11 = ww + xx - yy - zz;
    r21 = 2 * (xy + wz);
    r31 = 2 * (xz - wy);
    r32 = 2 * (yz + wx);
    r33 = ww - xx - yy + zz;
    mag = (r31 < 0) ? -r31 : r31;
    e.lock = (mag > longint'(lock_thr));
    if (e.lock) begin
      r12 = 2 * (xy - wz);
      r13 = 2 * (xz + wy);
      prod = fmul(clip(r31, 2 * one), clip(r13, 2 * one));
      e.roll = '0;
      e.pitch = clip32((r31 > 0) ? -longint'(HALF_PI) : longint'(HALF_PI));
      e.yaw = clip32(vec_atan2(-r12, -prod));
    end else begin
      e.roll = clip32(vec_atan2(r32, r33));
      // asin: clamp to +-1, cosine from exact integer root
      s = clip(-r31, one);
      c = root64(longint'(one << 30) - s * s);
      e.pitch = clip32(vec_atan2(s, c));
      e.yaw = clip32(vec_atan2(r21, r11));
    end
    return e;
  endfunction

  // ------------------------------------------------------------------ driver
  quat_t  quat_q[$];    // words waiting to be sent
  euler_t angles_q[$];  // predicted angles, oldest first
  int     send_gap = 0;
  bit     send_idle = 1'b1;
  int     words_sent = 0;

  always @(posedge clk) begin
    quat_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        angles_q.push_back(euler_of({quat_w, quat_x, quat_y, quat_z}));
        words_sent++;
        // alternate stretches with and without idle cycles
        if (words_sent % 80 == 0) send_idle = !send_idle;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (quat_q.size() > 0) begin
          q = quat_q.pop_front();
          quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
          in_valid <= 1'b1;
          send_gap = send_idle ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  int errors = 0;
  int words_checked = 0;
  int locks_seen = 0;
  int hold_cnt = 0;
  bit recv_idle = 1'b1;

  always @(posedge clk) begin
    euler_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (gimbal_lock) locks_seen++;
        if (words_checked % 97 == 0) recv_idle = !recv_idle;
        if (angles_q.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          e = angles_q.pop_front();
          if (angle_about_x !== e.roll) begin
            $error("angle_about_x exp %0d got %0d", e.roll, angle_about_x);
            errors++;
          end
          if (angle_about_y !== e.pitch) begin
            $error("angle_about_y exp %0d got %0d", e.pitch, angle_about_y);
            errors++;
          end
          if (angle_about_z !== e.yaw) begin
            $error("angle_about_z exp %0d got %0d", e.yaw, angle_about_z);
            errors++;
          end
          if (gimbal_lock !== e.lock) begin
            $error("gimbal_lock exp %0d got %0d", e.lock, gimbal_lock);
            errors++;
          end
        end
        hold_cnt = recv_idle ? $urandom_range(0, 7) : 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt > 0);
    end
  end

  // --------------------------------------------------------------- stimulus
  function automatic quat_t raw_quat();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // random unit quaternion, Q2.30
  function automatic quat_t unit_quat();
    real a, b, c, d, n;
    quat_t q;
    a = real'($urandom_range(0, 2000000)) - 1.0e6;
    b = real'($urandom_range(0, 2000000)) - 1.0e6;
    c = real'($urandom_range(0, 2000000)) - 1.0e6;
    d = real'($urandom_range(0, 2000000)) - 1.0e6;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    q.w = $rtoi(a / n * 1073741824.0);
    q.x = $rtoi(b / n * 1073741824.0);
    q.y = $rtoi(c / n * 1073741824.0);
    q.z = $rtoi(d / n * 1073741824.0);
    return q;
  endfunction

  // pitch near +-90 deg: w ~ +-y, x ~ -+z, small perturbation
  function automatic quat_t near_lock_quat();
    quat_t q;
    int a, b, sgn;
    a = $urandom_range(300000000, 759250125);
    b = $rtoi($sqrt(0.5 * 1073741824.0 * 1073741824.0 - real'(a) * real'(a)));
    sgn = $urandom_range(0, 1) ? 1 : -1;
    q.w = a + $urandom_range(0, 40) - 20;
    q.y = sgn * a + $urandom_range(0, 40) - 20;
    q.x = b + $urandom_range(0, 40) - 20;
    q.z = -sgn * b + $urandom_range(0, 40) - 20;
    return q;
  endfunction

  task automatic load_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) quat_q.push_back(unit_quat());
      else if (pick < 75) quat_q.push_back(near_lock_quat());
      else quat_q.push_back(raw_quat());
    end
  endtask

  task automatic wait_drained();
    wait (quat_q.size() == 0 && !in_valid && angles_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [TW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    lock_thr = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam logic signed [QW-1:0] ONE  = 32'sd1073741824;
  localparam logic signed [QW-1:0] HALF = 32'sd759250125;  // sqrt(0.5) in Q2.30
  localparam logic signed [QW-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [QW-1:0] MINV = 32'sh80000000;

  initial begin
    logic [TW-1:0] thr_list [5];
    thr_list = '{31'd0, 31'd1073741824, 31'd536870912, 31'd1073741823, LOCK_RESET};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset threshold
    quat_q.push_back('{ONE, 0, 0, 0});         // identity
    quat_q.push_back('{0, 0, 0, 0});           // atan2 of zero and zero
    quat_q.push_back('{0, ONE, 0, 0});         // 180 deg about x
    quat_q.push_back('{0, 0, ONE, 0});
    quat_q.push_back('{0, 0, 0, ONE});
    quat_q.push_back('{-ONE, 0, 0, 0});
    quat_q.push_back('{HALF, 0, HALF, 0});     // pitch +90: lock
    quat_q.push_back('{HALF, 0, -HALF, 0});    // pitch -90: lock
    quat_q.push_back('{HALF, HALF, HALF, -HALF});
    quat_q.push_back('{HALF, HALF, 0, 0});
    quat_q.push_back('{HALF, 0, 0, -HALF});
    quat_q.push_back('{MAXV, MAXV, MAXV, MAXV});
    quat_q.push_back('{MINV, MINV, MINV, MINV});
    quat_q.push_back('{MAXV, MINV, MAXV, MINV});
    quat_q.push_back('{MINV, 0, MAXV, 0});     // huge r31, lock product clamps
    quat_q.push_back('{MAXV, MAXV, MINV, MAXV});
    quat_q.push_back('{-1, -1, -1, -1});
    quat_q.push_back('{1, 1, 1, 1});
    load_random(PHASE_ITEMS);
    wait_drained();

    // one phase per threshold setting, extremes included
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      load_random(PHASE_ITEMS);
      wait_drained();
    end

    $display("checked %0d angle words (%0d under gimbal lock) across %0d thresholds",
             words_checked, locks_seen, 6);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
